[hdl/keq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keq_pkg
// Types, key codes and the US layout table shared by the key event queue.
// ----------------------------------------------------------------------------
package keq_pkg;

    // request types
    localparam logic [1:0] REQ_PRESS   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // special key codes
    localparam logic [7:0] KEY_LSHIFT = 8'h80;
    localparam logic [7:0] KEY_RSHIFT = 8'h8b;
    localparam logic [7:0] KEY_LCTRL  = 8'ha0;
    localparam logic [7:0] KEY_RCTRL  = 8'ha7;
    localparam logic [7:0] KEY_LALT   = 8'ha2;
    localparam logic [7:0] KEY_RALT   = 8'ha4;
    localparam logic [7:0] KEY_CAPS   = 8'h60;

    localparam logic [6:0] CTRL_MASK = 7'h1f;

    // modifier bit positions
    localparam int MB_LSHIFT = 0;
    localparam int MB_RSHIFT = 1;
    localparam int MB_LCTRL  = 2;
    localparam int MB_RCTRL  = 3;
    localparam int MB_LALT   = 4;
    localparam int MB_RALT   = 5;
    localparam int MB_CAPS   = 6;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] key_code;
        logic [6:0] read_count;
    } req_t;

    typedef struct packed {
        logic [6:0] char_out;
        logic       has_char;
        logic       last_of_run;
        logic [8:0] level_after;
    } res_t;

    typedef struct packed {
        logic       is_read;
        logic [6:0] ch;
        logic [6:0] count;
    } cmd_t;

    function automatic logic [6:0] mod_of_key(input logic [7:0] key);
        logic [6:0] m;
        begin
            m = '0;
            case (key)
                KEY_LSHIFT: m[MB_LSHIFT] = 1'b1;
                KEY_RSHIFT: m[MB_RSHIFT] = 1'b1;
                KEY_LCTRL:  m[MB_LCTRL]  = 1'b1;
                KEY_RCTRL:  m[MB_RCTRL]  = 1'b1;
                KEY_LALT:   m[MB_LALT]   = 1'b1;
                KEY_RALT:   m[MB_RALT]   = 1'b1;
                default:    m = '0;
            endcase
            return m;
        end
    endfunction

    // two-layer layout table, zero for unmapped keys
    function automatic logic [6:0] layout_char(input logic layer, input logic [7:0] key);
        logic [6:0] ch;
        begin
            ch = '0;
            case (key)
                8'h20: ch = layer ? 7'h7e : 7'h60;
                8'h21: ch = layer ? 7'h21 : 7'h31;
                8'h22: ch = layer ? 7'h40 : 7'h32;
                8'h23: ch = layer ? 7'h23 : 7'h33;
                8'h24: ch = layer ? 7'h24 : 7'h34;
                8'h25: ch = layer ? 7'h25 : 7'h35;
                8'h26: ch = layer ? 7'h5e : 7'h36;
                8'h27: ch = layer ? 7'h26 : 7'h37;
                8'h28: ch = layer ? 7'h2a : 7'h38;
                8'h29: ch = layer ? 7'h28 : 7'h39;
                8'h2a: ch = layer ? 7'h29 : 7'h30;
                8'h2b: ch = layer ? 7'h5f : 7'h2d;
                8'h2c: ch = layer ? 7'h2b : 7'h3d;
                8'h2d: ch = 7'h08;
                8'h32: ch = 7'h2f;
                8'h33: ch = 7'h2a;
                8'h34: ch = 7'h2d;
                8'h40: ch = 7'h09;
                8'h41: ch = layer ? 7'h51 : 7'h71;
                8'h42: ch = layer ? 7'h57 : 7'h77;
                8'h43: ch = layer ? 7'h45 : 7'h65;
                8'h44: ch = layer ? 7'h52 : 7'h72;
                8'h45: ch = layer ? 7'h54 : 7'h74;
                8'h46: ch = layer ? 7'h59 : 7'h79;
                8'h47: ch = layer ? 7'h55 : 7'h75;
                8'h48: ch = layer ? 7'h49 : 7'h69;
                8'h49: ch = layer ? 7'h4f : 7'h6f;
                8'h4a: ch = layer ? 7'h50 : 7'h70;
                8'h4b: ch = layer ? 7'h7b : 7'h5b;
                8'h4c: ch = layer ? 7'h7d : 7'h5d;
                8'h4d: ch = layer ? 7'h7c : 7'h5c;
                8'h51: ch = 7'h37;
                8'h52: ch = 7'h38;
                8'h53: ch = 7'h39;
                8'h54: ch = 7'h2b;
                8'h61: ch = layer ? 7'h41 : 7'h61;
                8'h62: ch = layer ? 7'h53 : 7'h73;
                8'h63: ch = layer ? 7'h44 : 7'h64;
                8'h64: ch = layer ? 7'h46 : 7'h66;
                8'h65: ch = layer ? 7'h47 : 7'h67;
                8'h66: ch = layer ? 7'h48 : 7'h68;
                8'h67: ch = layer ? 7'h4a : 7'h6a;
                8'h68: ch = layer ? 7'h4b : 7'h6b;
                8'h69: ch = layer ? 7'h4c : 7'h6c;
                8'h6a: ch = layer ? 7'h3a : 7'h3b;
                8'h6b: ch = layer ? 7'h22 : 7'h27;
                8'h6c: ch = 7'h0a;
                8'h6d: ch = 7'h34;
                8'h6e: ch = 7'h35;
                8'h6f: ch = 7'h36;
                8'h81: ch = layer ? 7'h5a : 7'h7a;
                8'h82: ch = layer ? 7'h58 : 7'h78;
                8'h83: ch = layer ? 7'h43 : 7'h63;
                8'h84: ch = layer ? 7'h56 : 7'h76;
                8'h85: ch = layer ? 7'h42 : 7'h62;
                8'h86: ch = layer ? 7'h4e : 7'h6e;
                8'h87: ch = layer ? 7'h4d : 7'h6d;
                8'h88: ch = layer ? 7'h3c : 7'h2c;
                8'h89: ch = layer ? 7'h3e : 7'h2e;
                8'h8a: ch = layer ? 7'h3f : 7'h2f;
                8'h8d: ch = 7'h31;
                8'h8e: ch = 7'h32;
                8'h8f: ch = 7'h33;
                8'h90: ch = 7'h0a;
                8'ha3: ch = 7'h20;
                8'hab: ch = 7'h30;
                8'hac: ch = 7'h2e;
                default: ch = '0;
            endcase
            return ch;
        end
    endfunction

endpackage

[hdl/keq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keq_front
// Accepts requests, tracks modifier keys and turns presses into characters.
// ----------------------------------------------------------------------------
module keq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  keq_pkg::req_t req,
    input  logic          cmd_full,
    output logic          cmd_push,
    output keq_pkg::cmd_t cmd
);
    import keq_pkg::*;

    logic [6:0] mod_reg;
    logic [6:0] mod_next;
    logic [6:0] key_mod;
    logic       layer;
    logic [6:0] rom_ch;
    logic       accept;

    assign req_ready = !cmd_full;
    assign accept    = req_valid && req_ready;
    assign key_mod   = mod_of_key(req.key_code);
    assign layer     = (mod_reg[MB_LSHIFT] | mod_reg[MB_RSHIFT]) ^ mod_reg[MB_CAPS];
    assign rom_ch    = layout_char(layer, req.key_code);

    always_comb
    begin
        mod_next    = mod_reg;
        cmd_push    = 1'b0;
        cmd.is_read = 1'b0;
        cmd.ch      = (mod_reg[MB_LCTRL] | mod_reg[MB_RCTRL]) ? (rom_ch & CTRL_MASK) : rom_ch;
        cmd.count   = req.read_count;
        if (accept)
        begin
            unique case (req.req_type)
                REQ_PRESS:
                begin
                    if (key_mod != '0)
                        mod_next = mod_reg | key_mod;
                    else if (req.key_code == KEY_CAPS)
                        mod_next[MB_CAPS] = ~mod_reg[MB_CAPS];
                    else if (rom_ch != '0)
                        cmd_push = 1'b1;
                end
                REQ_RELEASE:
                begin
                    mod_next = mod_reg & ~key_mod;
                end
                REQ_READ:
                begin
                    cmd_push    = 1'b1;
                    cmd.is_read = 1'b1;
                end
                default:
                begin
                    mod_next = mod_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= '0;
        else
            mod_reg <= mod_next;
    end

endmodule

[hdl/keq_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keq_cmd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module keq_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  keq_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output keq_pkg::cmd_t head_cmd
);
    import keq_pkg::*;

    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t               entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CW'(CMDQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[hdl/keq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keq_back
// Character queue: stores pushed characters and pops them for read commands.
// ----------------------------------------------------------------------------
module keq_back #(
    parameter int QUEUE_DEPTH = 256,
    parameter int MAX_READ    = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  keq_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          res_valid,
    input  logic          res_ready,
    output keq_pkg::res_t res
);
    import keq_pkg::*;

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int LW  = $clog2(QUEUE_DEPTH + 1);
    localparam int RW  = $clog2(MAX_READ + 1);
    localparam int CPW = (LW > RW) ? LW : RW;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic [6:0]    mem [QUEUE_DEPTH];
    logic [6:0]    mem_q_reg;

    logic          state_reg;
    logic          state_next;
    logic [AW-1:0] rp_reg;
    logic [AW-1:0] rp_next;
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [LW-1:0] fill_reg;
    logic [LW-1:0] fill_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_has_reg;
    logic          out_has_next;
    logic          out_last_reg;
    logic          out_last_next;
    logic [LW-1:0] out_level_reg;
    logic [LW-1:0] out_level_next;

    logic          slot_free;
    logic          mem_we;
    logic          mem_re;
    logic [RW-1:0] cnt_sat;
    logic [RW-1:0] n_pop;
    logic [AW-1:0] rp_inc;
    logic [AW-1:0] wp_inc;
    logic [LW+8:0] level_ext;

    assign slot_free = !out_valid_reg || res_ready;
    assign rp_inc    = (rp_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign wp_inc    = (wp_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign cnt_sat   = (cmd.count > 7'(MAX_READ)) ? RW'(MAX_READ) : RW'(cmd.count);
    assign n_pop     = (CPW'(cnt_sat) < CPW'(fill_reg)) ? cnt_sat : RW'(fill_reg);

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        out_level_next = out_level_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!cmd.is_read)
                    begin
                        cmd_pop = 1'b1;
                        mem_we  = 1'b1;
                        wp_next = wp_inc;
                        // full queue drops its oldest character
                        if (fill_reg == LW'(QUEUE_DEPTH))
                            rp_next = rp_inc;
                        else
                            fill_next = fill_reg + 1'b1;
                    end
                    else if (n_pop == '0)
                    begin
                        if (slot_free)
                        begin
                            cmd_pop        = 1'b1;
                            out_valid_next = 1'b1;
                            out_has_next   = 1'b0;
                            out_last_next  = 1'b1;
                            out_level_next = fill_reg;
                        end
                    end
                    else
                    begin
                        cmd_pop    = 1'b1;
                        rem_next   = n_pop;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    mem_re         = 1'b1;
                    rp_next        = rp_inc;
                    fill_next      = fill_reg - 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    out_valid_next = 1'b1;
                    out_has_next   = 1'b1;
                    out_last_next  = (rem_reg == RW'(1));
                    out_level_next = fill_reg - 1'b1;
                    if (rem_reg == RW'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
        out_level_reg <= out_level_next;
    end

    // character store with registered read, read data feeds the result
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= cmd.ch;
        if (mem_re)
            mem_q_reg <= mem[rp_reg];
    end

    assign level_ext       = {9'd0, out_level_reg};
    assign res_valid       = out_valid_reg;
    assign res.char_out    = out_has_reg ? mem_q_reg : 7'd0;
    assign res.has_char    = out_has_reg;
    assign res.last_of_run = out_last_reg;
    assign res.level_after = level_ext[8:0];

endmodule

[hdl/key_event_to_ascii_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_to_ascii_queue_unit
// Key press and release events to ASCII, queued and popped on read requests.
// ----------------------------------------------------------------------------
// The front takes one request per cycle while its two-entry command queue has
// room: modifier and caps lock keys update state there, and a mapped press or
// a read becomes a command. The back runs one command at a time: a character
// push and an empty read end in the idle state; other reads go to the read
// state, where the single read port of the character store pops one character
// per cycle while the output slot is free. Results leave through an output
// register, so pops continue at full rate while the consumer keeps ready high.
module key_event_to_ascii_queue_unit #(
    parameter int QUEUE_DEPTH = 256,
    parameter int MAX_READ    = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  keq_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output keq_pkg::res_t res
);
    import keq_pkg::*;

    logic cmd_full;
    logic cmd_push;
    cmd_t front_cmd;
    logic cmd_pop;
    logic head_valid;
    cmd_t head_cmd;

    keq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    keq_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (front_cmd),
        .full       (cmd_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    keq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_READ    (MAX_READ)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // an empty read always closes its run
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.has_char) |-> res.last_of_run)
        else $error("empty read result without last_of_run");

    // no character value leaks onto an empty result
    a_empty_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.has_char) |-> (res.char_out == 7'd0))
        else $error("empty read result carries a character");

    // after a pop the queue can never be full
    a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.has_char) |->
            ((QUEUE_DEPTH >= 512) || (res.level_after < 9'(QUEUE_DEPTH))))
        else $error("level after pop out of range");

    // a command is only popped while one is queued
    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> head_valid)
        else $error("command popped from an empty queue");

endmodule

[tb/tb_key_event_to_ascii_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_event_to_ascii_queue_unit
// Self-checking bench for the key event to ASCII queue. Press, release and
// read requests go in through a bursty driver; a local model of the modifier
// state, the layout table and the character queue predicts every popped
// character, which the monitor checks field by field under random stalls.
// ----------------------------------------------------------------------------
module tb_key_event_to_ascii_queue_unit;

    import keq_pkg::*;

    localparam int QDEPTH  = 256;
    localparam int MAX_POP = 64;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    req_t  req = '0;
    logic  res_valid;
    logic  res_ready = 1'b0;
    res_t  res;

    // model state
    logic [6:0] keymap [2][256];
    logic [6:0] char_fifo[$];
    logic [6:0] held_mods = '0;
    res_t       pops_owed[$];

    req_t       pending_reqs[$];
    int         n_queued = 0;
    int         n_taken = 0;
    int         errors = 0;

    logic       req_fire = 1'b0;
    int         burst_left = 1;
    int         gap_left = 0;
    logic [6:0] stall_phase = '0;
    int         stall_style = 0;
    logic [15:0] stall_mask = '1;

    key_event_to_ascii_queue_unit #(
        .QUEUE_DEPTH(QDEPTH),
        .MAX_READ(MAX_POP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // layout table and model
    // ------------------------------------------------------------------
    task automatic set_row(input int layer, input int base, input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            keymap[layer][base + i] = 7'(s[i]);
        end
    endtask

    task automatic build_keymap();
        for (int l = 0; l < 2; l++)
        begin
            for (int k = 0; k < 256; k++)
            begin
                keymap[l][k] = '0;
            end
            set_row(l, 'h32, "/*-");
            set_row(l, 'h51, "789+");
            set_row(l, 'h6d, "456");
            set_row(l, 'h8d, "123");
            set_row(l, 'hab, "0.");
            keymap[l]['h2d] = 7'h08;
            keymap[l]['h40] = 7'h09;
            keymap[l]['h6c] = 7'h0a;
            keymap[l]['h90] = 7'h0a;
            keymap[l]['ha3] = 7'h20;
        end
        set_row(0, 'h20, "`1234567890-=");
        set_row(1, 'h20, "~!@#$%^&*()_+");
        set_row(0, 'h41, "qwertyuiop[]\\");
        set_row(1, 'h41, "QWERTYUIOP{}|");
        set_row(0, 'h61, "asdfghjkl;'");
        set_row(1, 'h61, "ASDFGHJKL:\"");
        set_row(0, 'h81, "zxcvbnm,./");
        set_row(1, 'h81, "ZXCVBNM<>?");
    endtask

    function automatic logic [6:0] modifier_mask(input logic [7:0] key);
        case (key)
            KEY_LSHIFT: return 7'd1 << MB_LSHIFT;
            KEY_RSHIFT: return 7'd1 << MB_RSHIFT;
            KEY_LCTRL:  return 7'd1 << MB_LCTRL;
            KEY_RCTRL:  return 7'd1 << MB_RCTRL;
            KEY_LALT:   return 7'd1 << MB_LALT;
            KEY_RALT:   return 7'd1 << MB_RALT;
            default:    return 7'd0;
        endcase
    endfunction

    task automatic take_request(input req_t r);
        logic [6:0]  m;
        logic [6:0]  ch;
        logic        layer;
        int unsigned want;
        int unsigned n;
        res_t        p;
        m = modifier_mask(r.key_code);
        case (r.req_type)
            REQ_PRESS:
            begin
                if (m != '0)
                    held_mods = held_mods | m;
                else if (r.key_code == KEY_CAPS)
                    held_mods[MB_CAPS] = ~held_mods[MB_CAPS];
                else
                begin
                    layer = (held_mods[MB_LSHIFT] | held_mods[MB_RSHIFT]) ^ held_mods[MB_CAPS];
                    ch = keymap[layer][r.key_code];
                    if (ch != '0)
                    begin
                        if (held_mods[MB_LCTRL] | held_mods[MB_RCTRL])
                            ch = ch & CTRL_MASK;
                        // full queue drops its oldest character
                        if (char_fifo.size() >= QDEPTH)
                            void'(char_fifo.pop_front());
                        char_fifo.push_back(ch);
                    end
                end
            end
            REQ_RELEASE:
                held_mods = held_mods & ~m;
            REQ_READ:
            begin
                want = (r.read_count > MAX_POP) ? MAX_POP : r.read_count;
                n = (want < char_fifo.size()) ? want : char_fifo.size();
                if (n == 0)
                begin
                    p.char_out    = '0;
                    p.has_char    = 1'b0;
                    p.last_of_run = 1'b1;
                    p.level_after = 9'(char_fifo.size());
                    pops_owed.push_back(p);
                end
                for (int unsigned k = 0; k < n; k++)
                begin
                    p.char_out    = char_fifo.pop_front();
                    p.has_char    = 1'b1;
                    p.last_of_run = (k + 1 == n);
                    p.level_after = 9'(char_fifo.size());
                    pops_owed.push_back(p);
                end
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add(input logic [1:0] kind, input logic [7:0] key, input logic [6:0] cnt);
        req_t r;
        r.req_type   = kind;
        r.key_code   = key;
        r.read_count = cnt;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    function automatic logic [7:0] mapped_key();
        logic [7:0] k;
        k = 8'($urandom_range(0, 255));
        while (keymap[0][k] == '0)
            k = 8'($urandom_range(0, 255));
        return k;
    endfunction

    function automatic logic [7:0] special_key();
        case ($urandom_range(0, 6))
            0: return KEY_LSHIFT;
            1: return KEY_RSHIFT;
            2: return KEY_LCTRL;
            3: return KEY_RCTRL;
            4: return KEY_LALT;
            5: return KEY_RALT;
            default: return KEY_CAPS;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver, receiver and monitor
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        // hold the current item until its transfer
        if (rst_n && !(req_valid && !req_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_phase <= stall_phase + 7'd1;
            if (stall_phase == '0)
            begin
                stall_style <= $urandom_range(0, 3);
                stall_mask <= 16'($urandom);
            end
            case (stall_style)
                0: res_ready <= 1'b1;
                1: res_ready <= 1'($urandom_range(0, 1));
                2: res_ready <= stall_mask[stall_phase[3:0]];
                default: res_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : monitor
        res_t due;
        req_fire <= rst_n && req_valid && req_ready;
        if (rst_n && req_valid && req_ready)
        begin
            take_request(req);
            n_taken++;
        end
        if (rst_n && res_valid && res_ready)
        begin
            if (pops_owed.size() == 0)
                report("unexpected transfer, level_after", res.level_after, -1);
            else
            begin
                due = pops_owed.pop_front();
                if (res.char_out !== due.char_out)
                    report("char_out", res.char_out, due.char_out);
                if (res.has_char !== due.has_char)
                    report("has_char", res.has_char, due.has_char);
                if (res.last_of_run !== due.last_of_run)
                    report("last_of_run", res.last_of_run, due.last_of_run);
                if (res.level_after !== due.level_after)
                    report("level_after", res.level_after, due.level_after);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        logic [7:0] k;
        build_keymap();

        // empty queue reads, plain and oversized count
        add(REQ_READ, 8'h00, 7'd0);
        add(REQ_READ, 8'hff, 7'd127);
        // plain, shifted, caps and shift against caps
        add(REQ_PRESS, 8'h41, 7'd0);
        add(REQ_PRESS, KEY_LSHIFT, 7'd0);
        add(REQ_PRESS, 8'h41, 7'd0);
        add(REQ_RELEASE, KEY_LSHIFT, 7'd0);
        add(REQ_PRESS, KEY_CAPS, 7'd0);
        add(REQ_PRESS, 8'h61, 7'd0);
        add(REQ_PRESS, KEY_RSHIFT, 7'd0);
        add(REQ_PRESS, 8'h61, 7'd0);
        add(REQ_RELEASE, KEY_RSHIFT, 7'd0);
        add(REQ_RELEASE, KEY_CAPS, 7'd0);
        add(REQ_PRESS, KEY_CAPS, 7'd0);
        // ctrl masking, including a character that masks to zero
        add(REQ_PRESS, KEY_LCTRL, 7'd0);
        add(REQ_PRESS, 8'h63, 7'd0);
        add(REQ_PRESS, 8'h20, 7'd0);
        add(REQ_RELEASE, KEY_LCTRL, 7'd0);
        add(REQ_PRESS, KEY_RCTRL, 7'd0);
        add(REQ_PRESS, 8'h42, 7'd0);
        add(REQ_RELEASE, KEY_RCTRL, 7'd0);
        // alt is tracked but has no effect
        add(REQ_PRESS, KEY_LALT, 7'd0);
        add(REQ_PRESS, KEY_RALT, 7'd0);
        add(REQ_PRESS, 8'h44, 7'd0);
        add(REQ_RELEASE, KEY_LALT, 7'd0);
        // unmapped keys, plain key release, unused request type
        add(REQ_PRESS, 8'hff, 7'd0);
        add(REQ_RELEASE, 8'h41, 7'd0);
        add(2'd3, 8'hff, 7'd127);
        // zero count on a non-empty queue, then a saturating read
        add(REQ_READ, 8'h00, 7'd0);
        add(REQ_READ, 8'h00, 7'd127);

        // mixed traffic
        for (int i = 0; i < 24; i++)
        begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 9) < 3) ? special_key() : 8'($urandom_range(0, 255));
            if (r < 40)
                add(REQ_PRESS, k, 7'($urandom_range(0, 127)));
            else if (r < 60)
                add(REQ_RELEASE, k, 7'($urandom_range(0, 127)));
            else if (r < 95)
            begin
                r = $urandom_range(0, 9);
                add(REQ_READ, k, (r < 7) ? 7'($urandom_range(0, 16)) :
                    (r < 9) ? 7'($urandom_range(17, 64)) : 7'($urandom_range(65, 127)));
            end
            else
                add(2'd3, k, 7'($urandom_range(0, 127)));
        end

        // typing run long enough to overflow the queue
        for (int i = 0; i < 272; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                add(2'($urandom_range(0, 1)), special_key(), 7'($urandom_range(0, 127)));
            if (i % 90 == 45)
                add(REQ_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 3)));
            add(REQ_PRESS, mapped_key(), 7'($urandom_range(0, 127)));
        end

        // drain past empty, with a little typing mixed in
        for (int i = 0; i < 7; i++)
        begin
            add(REQ_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(60, 127)));
            add(REQ_PRESS, mapped_key(), 7'($urandom_range(0, 127)));
        end
        add(REQ_RELEASE, KEY_LSHIFT, 7'd0);
        add(REQ_RELEASE, KEY_LCTRL, 7'd0);
        for (int i = 0; i < 12; i++)
        begin
            add(REQ_PRESS, mapped_key(), 7'd0);
            if (i % 4 == 3)
                add(REQ_READ, 8'h00, 7'($urandom_range(1, 5)));
        end
        add(REQ_READ, 8'h00, 7'd127);
        add(REQ_READ, 8'h00, 7'd64);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_taken < n_queued)
            @(posedge clk);
        while (pops_owed.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("** key_event_to_ascii_queue_unit: PASSED **");
        else
            $display("** key_event_to_ascii_queue_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d of %0d requests taken, %0d pops owed",
                 n_taken, n_queued, pops_owed.size());
        $display("** key_event_to_ascii_queue_unit: FAILED **");
        $finish;
    end

endmodule
